// ----- hw/rtl/fpexp_pkg.sv -----
// ---------------------------------------------------------------------------
// Fixed-point exponential package
// Widths, logarithm constants and the payload types shared by the pipeline.
// ---------------------------------------------------------------------------
package fpexp_pkg;

   // Argument and result widths
   localparam int X_W     = 32;
   localparam int RES_W   = 31;
   // Reduced argument stays below the saturation limit: 19 bits
   localparam int V_W     = 19;
   localparam int SHIFT_W = 4;

   localparam int BIG_COUNT   = 4;
   localparam int SMALL_COUNT = 7;
   localparam int NEG_COUNT   = 6;

   // Small steps handled in the third stage; the rest go to the last stage
   localparam int SMALL_SPLIT = 4;

   localparam logic [RES_W-1:0]        EXP_ONE       = 31'h0000_8000;
   localparam logic [RES_W-1:0]        EXP_SAT_VALUE = 31'h7FFF_FFFF;
   localparam logic signed [X_W-1:0]   EXP_SAT_LIMIT = 32'sd363409;

   // ln 256, ln 16, ln 4, ln 2 in Q16.15 and the matching left shifts
   localparam logic [V_W-1:0] BIG_LOGS [BIG_COUNT] = '{
      19'd181705, 19'd90852, 19'd45426, 19'd22711
   };
   localparam logic [SHIFT_W-1:0] BIG_SHIFTS [BIG_COUNT] = '{
      4'd8, 4'd4, 4'd2, 4'd1
   };

   // ln(1 + 2^-k) for k = 1..7 in Q16.15
   localparam logic [V_W-1:0] SMALL_LOGS [SMALL_COUNT] = '{
      19'd13287, 19'd7310, 19'd3860, 19'd1985, 19'd1009, 19'd507, 19'd255
   };

   // Negative range: added logarithm and final right shift
   localparam logic signed [X_W-1:0] NEG_LOGS [NEG_COUNT] = '{
      32'sd22711, 32'sd45426, 32'sd90852, 32'sd181705, 32'sd272557, 32'sd340695
   };
   localparam logic [SHIFT_W-1:0] NEG_SHIFTS [NEG_COUNT] = '{
      4'd1, 4'd2, 4'd4, 4'd8, 4'd12, 4'd15
   };

   // Argument after range reduction
   typedef struct packed {
      logic [V_W-1:0]     v;
      logic [SHIFT_W-1:0] shift;
      logic               zero;
      logic               sat;
   } range_type;

   // Payload carried between pipeline stages
   typedef struct packed {
      logic [V_W-1:0]     v;
      logic [RES_W-1:0]   y;
      logic [SHIFT_W-1:0] shift;
      logic               zero;
      logic               sat;
   } stage_type;

endpackage

// ----- hw/rtl/fixed_point_exponential.sv -----
// ---------------------------------------------------------------------------
// Fixed-point exponential
// exp(x) of a signed Q16.15 argument by shift-and-add, Q16.15 result.
// ---------------------------------------------------------------------------
// One request is accepted every cycle while rsp_stall is low; each request
// passes through four register stages: range reduction, the four large
// logarithm steps, small steps k = 1..4, and small steps k = 5..7 with the
// final right shift into the output register.
// Bubbles collapse, so a request is still taken while a finished result waits
// on rsp_stall, as long as an earlier stage is empty. Arguments of 363409 or
// more clamp to 0x7FFFFFFF with rsp_saturated set; arguments of -340695 or
// less return 0.
// ---------------------------------------------------------------------------
module fixed_point_exponential (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fpexp_pkg::X_W-1:0]  req_x_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fpexp_pkg::RES_W-1:0]       rsp_result,
   output logic                              rsp_saturated
);

   fpexp_pkg::range_type range_w;

   fpexp_pkg::stage_type s1_ff, s2_ff, s3_ff;
   fpexp_pkg::stage_type s1_in, s2_in, s3_in;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [fpexp_pkg::RES_W-1:0] result_ff, result_in;
   logic saturated_ff;

   logic s1_ready, s2_ready, s3_ready, out_ready;

   // Stage 1 logic: range reduction
   fpexp_range u_range (
      .x_in      (req_x_in),
      .range_out (range_w)
   );

   always_comb begin
      s1_in       = '0;
      s1_in.v     = range_w.v;
      s1_in.y     = fpexp_pkg::EXP_ONE;
      s1_in.shift = range_w.shift;
      s1_in.zero  = range_w.zero;
      s1_in.sat   = range_w.sat;
   end

   // Stage 2 logic: large logarithm steps, result shifts left
   always_comb begin
      s2_in = s1_ff;
      for (int i = 0; i < fpexp_pkg::BIG_COUNT; i++) begin
         if (s2_in.v >= fpexp_pkg::BIG_LOGS[i]) begin
            s2_in.v = s2_in.v - fpexp_pkg::BIG_LOGS[i];
            s2_in.y = s2_in.y << fpexp_pkg::BIG_SHIFTS[i];
         end
      end
   end

   // Stage 3 logic: first small steps, result grows by its own shift
   always_comb begin
      s3_in = s2_ff;
      for (int i = 0; i < fpexp_pkg::SMALL_SPLIT; i++) begin
         if (s3_in.v >= fpexp_pkg::SMALL_LOGS[i]) begin
            s3_in.v = s3_in.v - fpexp_pkg::SMALL_LOGS[i];
            s3_in.y = s3_in.y + (s3_in.y >> (i + 1));
         end
      end
   end

   // Stage 4 logic: remaining small steps, final shift and special cases
   always_comb begin
      logic [fpexp_pkg::V_W-1:0]   v;
      logic [fpexp_pkg::RES_W-1:0] y;
      v = s3_ff.v;
      y = s3_ff.y;
      for (int i = fpexp_pkg::SMALL_SPLIT; i < fpexp_pkg::SMALL_COUNT; i++) begin
         if (v >= fpexp_pkg::SMALL_LOGS[i]) begin
            v = v - fpexp_pkg::SMALL_LOGS[i];
            y = y + (y >> (i + 1));
         end
      end
      if (s3_ff.sat) begin
         result_in = fpexp_pkg::EXP_SAT_VALUE;
      end else if (s3_ff.zero) begin
         result_in = '0;
      end else begin
         result_in = y >> s3_ff.shift;
      end
   end

   // Backpressure: a stage loads when it is empty or its content moves on
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) out_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready)  s1_ff <= s1_in;
      if (s2_ready)  s2_ff <= s2_in;
      if (s3_ready)  s3_ff <= s3_in;
      if (out_ready) begin
         result_ff    <= result_in;
         saturated_ff <= s3_ff.sat;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_result    = result_ff;
   assign rsp_saturated = saturated_ff;

endmodule

// ----- hw/rtl/fpexp_range.sv -----
// ---------------------------------------------------------------------------
// Fixed-point exponential range reduction
// Classifies the argument (saturate, non-negative, negative, underflow) and
// folds a negative argument into the positive range with a right shift.
// ---------------------------------------------------------------------------
module fpexp_range (
   input  logic signed [fpexp_pkg::X_W-1:0] x_in,
   output fpexp_pkg::range_type             range_out
);

   logic signed [fpexp_pkg::X_W-1:0] sums [fpexp_pkg::NEG_COUNT];
   logic                             found;

   // Candidate sums, all in parallel
   always_comb begin
      for (int i = 0; i < fpexp_pkg::NEG_COUNT; i++) begin
         sums[i] = x_in + fpexp_pkg::NEG_LOGS[i];
      end
   end

   // Priority pick: first strictly positive sum wins
   always_comb begin
      range_out = '0;
      found     = 1'b0;
      if (x_in >= fpexp_pkg::EXP_SAT_LIMIT) begin
         range_out.sat = 1'b1;
      end else if (!x_in[fpexp_pkg::X_W-1]) begin
         range_out.v = x_in[fpexp_pkg::V_W-1:0];
      end else begin
         for (int i = 0; i < fpexp_pkg::NEG_COUNT; i++) begin
            if (!found && (sums[i] > 0)) begin
               found           = 1'b1;
               range_out.v     = sums[i][fpexp_pkg::V_W-1:0];
               range_out.shift = fpexp_pkg::NEG_SHIFTS[i];
            end
         end
         // too negative for every offset: result underflows to zero
         range_out.zero = !found;
      end
   end

endmodule
